>>> rtl/core/lzwd_pkg.sv
// Shared constants for the LZSS window decoder.
package lzwd_pkg;

    localparam int unsigned WIN_DEPTH = 1024;
    localparam int unsigned WIN_AW    = 10;
    localparam int unsigned LEN_W     = 7;
    localparam int unsigned REM_W     = 24;

    localparam logic [WIN_AW-1:0] START_POS = 10'h3BE;
    localparam logic [LEN_W-1:0]  LEN_BIAS  = 7'd3;
    localparam logic [8:0]        FLAG_MARK = 9'h100;

endpackage

>>> rtl/core/lzwd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lzwd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // hold the last read word while no read is issued
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/lzss_window_decoder.sv
// Top level of the LZSS window decoder: parser, copy engine and result packing.
//
// Usage
//   Input channel (in_valid / in_stall, operation + in_byte): operation 0 starts a job,
//   operation 1 delivers one compressed byte. A transfer happens at a rising edge with
//   in_valid high and in_stall low. Output channel (out_valid / out_stall) carries the
//   decoded bytes, up to two per transfer, with last_of_run on the final result of an
//   input byte, and job_done / overrun on the result that ends the job.
//   Users must write output_length (cfg_write, cfg_data) only while the block is idle.
// Reset and job start
//   After reset, and after every start transfer, a clearing pass zeroes the 1024-byte
//   window one entry per cycle, with in_stall high. Configuration writes are taken
//   throughout, so the block itself does not enforce the idle-only output_length rule.
// Processing
//   Flag bytes and reference low bytes are taken in the idle state. A literal passes
//   through the write stage into the output register. A reference of length L (3 to 66)
//   reads one window byte per cycle through the single read port, unless out_stall
//   holds the output register full, forwarding a byte read in the cycle it is written.
// Back-pressure
//   A finished result waits in the output register while the next input is taken.
//   When out_stall holds that register full, the copy engine holds the byte that would
//   complete a result and issues no further window reads until the register drains.
module lzss_window_decoder
    import lzwd_pkg::*;
#(
    parameter int unsigned OUTPUT_LANES = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [REM_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             operation,
    input  logic [7:0]       in_byte,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       byte_first,
    output logic [7:0]       byte_second,
    output logic [1:0]       byte_count,
    output logic             last_of_run,
    output logic             job_done,
    output logic             overrun
);

    // up to two bytes per result unless a single lane is configured
    localparam bit PAIR_MODE = (OUTPUT_LANES >= 2);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COPY
    } state_t;

    typedef enum logic [1:0] {
        PH_FLAG,
        PH_LIT,
        PH_REFLO,
        PH_REFHI
    } phase_t;

    // control state
    state_t             state_reg,      state_next;
    logic [WIN_AW-1:0]  clr_cnt_reg,    clr_cnt_next;
    logic [WIN_AW-1:0]  wp_reg,         wp_next;
    logic [8:0]         flag_reg,       flag_next;
    phase_t             phase_reg,      phase_next;
    logic [7:0]         offlo_reg,      offlo_next;
    logic [REM_W-1:0]   rem_reg,        rem_next;
    logic               active_reg,     active_next;
    logic [REM_W-1:0]   olen_reg,       olen_next;
    logic [WIN_AW-1:0]  src_reg,        src_next;
    logic [LEN_W-1:0]   cnt_reg,        cnt_next;
    logic               w_valid_reg,    w_valid_next;
    logic               w_last_reg,     w_last_next;
    logic               w_lit_reg,      w_lit_next;
    logic               rd_hit_reg,     rd_hit_next;
    logic               half_valid_reg, half_valid_next;
    logic               done_reg,       done_next;
    logic               over_reg,       over_next;
    logic               out_valid_reg,  out_valid_next;
    logic               out_last_reg,   out_last_next;
    logic               out_done_reg,   out_done_next;
    logic               out_over_reg,   out_over_next;

    // payload
    logic [7:0]         lit_byte_reg,   lit_byte_next;
    logic [7:0]         fwd_byte_reg,   fwd_byte_next;
    logic [7:0]         half_byte_reg,  half_byte_next;
    logic [7:0]         out_b0_reg,     out_b0_next;
    logic [7:0]         out_b1_reg,     out_b1_next;
    logic [1:0]         out_cnt_reg,    out_cnt_next;

    // window RAM port
    logic               ram_we;
    logic [WIN_AW-1:0]  ram_waddr;
    logic [7:0]         ram_wdata;
    logic               ram_re;
    logic [7:0]         ram_rdata;

    // datapath helpers
    logic               accept;
    logic [7:0]         w_data;
    logic               completes;
    logic               out_free;
    logic               w_take;
    logic               issue;
    logic               push;
    logic [8:0]         flag_sh;
    phase_t             phase_adv;
    logic [LEN_W-1:0]   ref_len;
    logic [REM_W-1:0]   ref_len_ext;
    logic               ref_done;

    lzwd_ram #(
        .WIDTH (8),
        .DEPTH (WIN_DEPTH)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (src_reg),
        .rdata (ram_rdata)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && (state_reg == ST_IDLE);

    // byte at the write stage: a literal, a forwarded byte or the RAM word
    assign w_data    = w_lit_reg ? lit_byte_reg : (rd_hit_reg ? fwd_byte_reg : ram_rdata);
    assign completes = w_last_reg || half_valid_reg || !PAIR_MODE;
    assign out_free  = !out_valid_reg || !out_stall;
    assign w_take    = w_valid_reg && (!completes || out_free);
    assign issue     = (state_reg == ST_COPY) && (cnt_reg != '0) && (!w_valid_reg || w_take);
    assign push      = w_take && completes;

    assign ram_re    = issue;
    assign ram_we    = (state_reg == ST_CLEAR) || w_take;
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : wp_reg;
    assign ram_wdata = (state_reg == ST_CLEAR) ? 8'h00 : w_data;

    // flag shifter step after each literal or reference
    assign flag_sh   = {1'b0, flag_reg[8:1]};
    assign phase_adv = (flag_sh <= 9'd1) ? PH_FLAG : (flag_sh[0] ? PH_LIT : PH_REFLO);

    assign ref_len     = {1'b0, in_byte[5:0]} + LEN_BIAS;
    assign ref_len_ext = {{(REM_W-LEN_W){1'b0}}, ref_len};
    assign ref_done    = ref_len_ext >= rem_reg;

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        wp_next         = wp_reg;
        flag_next       = flag_reg;
        phase_next      = phase_reg;
        offlo_next      = offlo_reg;
        rem_next        = rem_reg;
        active_next     = active_reg;
        olen_next       = cfg_write ? cfg_data : olen_reg;
        src_next        = src_reg;
        cnt_next        = cnt_reg;
        w_valid_next    = w_valid_reg;
        w_last_next     = w_last_reg;
        w_lit_next      = w_lit_reg;
        rd_hit_next     = rd_hit_reg;
        half_valid_next = half_valid_reg;
        done_next       = done_reg;
        over_next       = over_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_last_next   = out_last_reg;
        out_done_next   = out_done_reg;
        out_over_next   = out_over_reg;
        lit_byte_next   = lit_byte_reg;
        fwd_byte_next   = fwd_byte_reg;
        half_byte_next  = half_byte_reg;
        out_b0_next     = out_b0_reg;
        out_b1_next     = out_b1_reg;
        out_cnt_next    = out_cnt_reg;

        // write stage: commit the byte to the window and pack it
        if (w_take)
        begin
            wp_next      = wp_reg + 10'd1;
            w_valid_next = 1'b0;
            if (completes)
            begin
                half_valid_next = 1'b0;
                out_valid_next  = 1'b1;
                out_b0_next     = half_valid_reg ? half_byte_reg : w_data;
                out_b1_next     = half_valid_reg ? w_data : 8'h00;
                out_cnt_next    = half_valid_reg ? 2'd2 : 2'd1;
                out_last_next   = w_last_reg;
                out_done_next   = w_last_reg && done_reg;
                out_over_next   = w_last_reg && over_reg;
            end
            else
            begin
                half_valid_next = 1'b1;
                half_byte_next  = w_data;
            end
        end

        // read stage: fetch the next reference byte, forward on a same-entry write
        if (issue)
        begin
            src_next      = src_reg + 10'd1;
            cnt_next      = cnt_reg - 7'd1;
            w_valid_next  = 1'b1;
            w_last_next   = (cnt_reg == 7'd1);
            w_lit_next    = 1'b0;
            rd_hit_next   = w_take && (wp_reg == src_reg);
            fwd_byte_next = w_data;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 10'd1;
                if (clr_cnt_reg == 10'h3FF)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_COPY:
            begin
                if (w_take && w_last_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!operation)
                    begin
                        state_next   = ST_CLEAR;
                        clr_cnt_next = '0;
                        wp_next      = START_POS;
                        flag_next    = '0;
                        phase_next   = PH_FLAG;
                        offlo_next   = '0;
                        rem_next     = olen_reg;
                        active_next  = (olen_reg != '0);
                    end
                    else if (active_reg)
                    begin
                        unique case (phase_reg)
                            PH_FLAG:
                            begin
                                flag_next  = FLAG_MARK | {1'b0, in_byte};
                                phase_next = in_byte[0] ? PH_LIT : PH_REFLO;
                            end
                            PH_REFLO:
                            begin
                                offlo_next = in_byte;
                                phase_next = PH_REFHI;
                            end
                            PH_LIT:
                            begin
                                state_next    = ST_COPY;
                                w_valid_next  = 1'b1;
                                w_last_next   = 1'b1;
                                w_lit_next    = 1'b1;
                                lit_byte_next = in_byte;
                                cnt_next      = '0;
                                rem_next      = rem_reg - 24'd1;
                                done_next     = (rem_reg == 24'd1);
                                over_next     = 1'b0;
                                active_next   = (rem_reg != 24'd1);
                                flag_next     = flag_sh;
                                phase_next    = phase_adv;
                            end
                            PH_REFHI:
                            begin
                                state_next  = ST_COPY;
                                src_next    = {in_byte[7:6], offlo_reg};
                                cnt_next    = ref_len;
                                rem_next    = ref_done ? '0 : (rem_reg - ref_len_ext);
                                done_next   = ref_done;
                                over_next   = ref_len_ext > rem_reg;
                                active_next = !ref_done;
                                flag_next   = flag_sh;
                                phase_next  = phase_adv;
                            end
                            default:
                            begin
                                phase_next = PH_FLAG;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            wp_reg         <= START_POS;
            flag_reg       <= '0;
            phase_reg      <= PH_FLAG;
            offlo_reg      <= '0;
            rem_reg        <= '0;
            active_reg     <= 1'b0;
            olen_reg       <= '0;
            src_reg        <= '0;
            cnt_reg        <= '0;
            w_valid_reg    <= 1'b0;
            w_last_reg     <= 1'b0;
            w_lit_reg      <= 1'b0;
            rd_hit_reg     <= 1'b0;
            half_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
            over_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
            out_done_reg   <= 1'b0;
            out_over_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            wp_reg         <= wp_next;
            flag_reg       <= flag_next;
            phase_reg      <= phase_next;
            offlo_reg      <= offlo_next;
            rem_reg        <= rem_next;
            active_reg     <= active_next;
            olen_reg       <= olen_next;
            src_reg        <= src_next;
            cnt_reg        <= cnt_next;
            w_valid_reg    <= w_valid_next;
            w_last_reg     <= w_last_next;
            w_lit_reg      <= w_lit_next;
            rd_hit_reg     <= rd_hit_next;
            half_valid_reg <= half_valid_next;
            done_reg       <= done_next;
            over_reg       <= over_next;
            out_valid_reg  <= out_valid_next;
            out_last_reg   <= out_last_next;
            out_done_reg   <= out_done_next;
            out_over_reg   <= out_over_next;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge clk)
    begin
        lit_byte_reg  <= lit_byte_next;
        fwd_byte_reg  <= fwd_byte_next;
        half_byte_reg <= half_byte_next;
        out_b0_reg    <= out_b0_next;
        out_b1_reg    <= out_b1_next;
        out_cnt_reg   <= out_cnt_next;
    end

    assign out_valid   = out_valid_reg;
    assign byte_first  = out_b0_reg;
    assign byte_second = out_b1_reg;
    assign byte_count  = out_cnt_reg;
    assign last_of_run = out_last_reg;
    assign job_done    = out_done_reg;
    assign overrun     = out_over_reg;

    // a job is live exactly while bytes remain to be produced
    a_active_rem: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg == (rem_reg != '0))
        else $error("job_active and remaining count disagree");

    // no byte in flight and no half-packed result once an input is finished
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!w_valid_reg && !half_valid_reg))
        else $error("byte left behind at end of input");

    // the write stage only holds a byte during a copy
    a_wstage_copy: assert property (@(posedge clk) disable iff (!rst_n)
        w_valid_reg |-> (state_reg == ST_COPY))
        else $error("write stage busy outside a copy");

    // overrun only ever marks the final result of the job
    a_over_final: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_over_reg) |-> (out_done_reg && out_last_reg))
        else $error("overrun on a result that does not end the job");

endmodule
